[rtl/srw_pkg.sv]
// Package for the sequence replay window block.
// Holds field widths, outcome codes and configuration register addresses.
// No dependencies.
package srw_pkg;

  localparam int SEQ_NUM_W   = 32;
  localparam int OUTCOME_W   = 2;
  localparam int WIN_CFG_W   = 7;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_ACCEPT   = 2'd0,
    OUT_OLD      = 2'd1,
    OUT_OVERFLOW = 2'd2
  } outcome_t;

  typedef enum logic [0:0] {
    OP_RECEIVE = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE    = 1'b0,
    REG_START_SEQUENCE = 1'b1
  } reg_sel_t;

endpackage

[rtl/srw_chan_if.sv]
// Valid/ready channel interfaces for the sequence replay window block.
// Depends on srw_pkg for the payload widths.
interface srw_in_if import srw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [SEQ_NUM_W-1:0] sequence_number;

  modport source (output valid, output opcode, output sequence_number, input ready);
  modport sink   (input valid, input opcode, input sequence_number, output ready);
endinterface

interface srw_out_if import srw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [SEQ_NUM_W-1:0] next_expected;

  modport source (output valid, output outcome, output next_expected, input ready);
  modport sink   (input valid, input outcome, input next_expected, output ready);
endinterface

[rtl/sequence_replay_window_core.sv]
// Sequence replay window: replay and duplicate filter for packet sequence numbers.
// Depends on srw_pkg and the channel interfaces in srw_chan_if.sv.
// Path per transaction: restart to result; old or in-window via ST_DECIDE; in-order via
// ST_STEP; jump via ST_JUMP steps of at most the window, ST_JEND, then ST_STEP if in order.
// One transaction in flight; a result waiting on out ready holds off further input.
// Reset (synchronous, rst_n low): window 64, start 0, expected 0, bitmap clear.
module sequence_replay_window_core import srw_pkg::*; #(
  parameter int MAX_WINDOW = 64,
  parameter int SEQ_WIDTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  srw_in_if.sink                in_ch,
  srw_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int MW = WW + 1;
  localparam int IW = $clog2(MAX_WINDOW);
  localparam int SW = SEQ_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_STEP, ST_JUMP, ST_JEND, ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [WIN_CFG_W-1:0]  window_r, window_nxt;
  logic [SEQ_NUM_W-1:0]  start_r, start_nxt;
  logic [SW-1:0]         exp_r, exp_nxt;
  logic [MAX_WINDOW-1:0] bitmap_r, bitmap_nxt;
  logic [SW-1:0]         n_r, n_nxt;
  logic [SW-1:0]         diff_r, diff_nxt;
  logic                  lt_r, lt_nxt;
  logic [WW-1:0]         w_r, w_nxt;
  logic [MW-1:0]         moved_r, moved_nxt;
  outcome_t              outcome_r, outcome_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0]  out_outcome_r, out_outcome_nxt;
  logic [SEQ_NUM_W-1:0]  out_next_r, out_next_nxt;

  logic                  in_acc;
  logic                  cfg_wr;
  logic [SW-1:0]         in_seq;
  logic [SW:0]           sub_full;
  logic [WW-1:0]         w_eff;
  logic [MAX_WINDOW-1:0] inv, low_bit, adv_bitmap;
  logic [WW-1:0]         tcount, step;
  logic [MW-1:0]         tp1, moved_sum;
  logic [MW:0]           jsum;
  logic [SW-1:0]         adv_exp;
  logic [IW-1:0]         idx_win, idx_jump;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;
  assign prdata        = (reg_sel_t'(paddr[2]) == REG_START_SEQUENCE) ?
                         start_r : APB_DATA_W'(window_r);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.outcome       = out_outcome_r;
  assign out_ch.next_expected = out_next_r;

  assign in_seq   = SW'(in_ch.sequence_number);
  assign sub_full = {1'b0, in_seq} - {1'b0, exp_r};

  always_comb begin
    if (window_r == '0) begin
      w_eff = WW'(1);
    end else if (window_r > WIN_CFG_W'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_r);
    end
  end

  // Shared advance unit: one step past the expected number and its trailing run, at most the window.
  always_comb begin
    inv     = ~bitmap_r;
    low_bit = inv & (~inv + MAX_WINDOW'(1));
    tcount  = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (low_bit[j]) begin
        tcount = tcount | WW'(j);
      end
    end
    if (inv == '0) begin
      tcount = WW'(MAX_WINDOW);
    end
    tp1        = MW'(tcount) + MW'(1);
    step       = (tp1 > MW'(w_r)) ? w_r : WW'(tp1);
    adv_exp    = exp_r + SW'(step);
    adv_bitmap = bitmap_r >> step;
  end

  assign moved_sum = moved_r + MW'(step);
  assign jsum      = (MW+1)'(moved_sum) + (MW+1)'(w_r);
  assign idx_win   = diff_r[IW-1:0] - IW'(1);
  assign idx_jump  = diff_r[IW-1:0] - moved_r[IW-1:0] - IW'(1);

  always_comb begin
    state_nxt       = state_r;
    window_nxt      = window_r;
    start_nxt       = start_r;
    exp_nxt         = exp_r;
    bitmap_nxt      = bitmap_r;
    n_nxt           = n_r;
    diff_nxt        = diff_r;
    lt_nxt          = lt_r;
    w_nxt           = w_r;
    moved_nxt       = moved_r;
    outcome_nxt     = outcome_r;
    out_valid_nxt   = out_valid_r;
    out_outcome_nxt = out_outcome_r;
    out_next_nxt    = out_next_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          n_nxt    = in_seq;
          diff_nxt = sub_full[SW-1:0];
          lt_nxt   = sub_full[SW];
          w_nxt    = w_eff;
          if (opcode_t'(in_ch.opcode) == OP_RESTART) begin
            exp_nxt     = '0;
            bitmap_nxt  = '0;
            outcome_nxt = OUT_ACCEPT;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        priority if (lt_r) begin
          outcome_nxt = OUT_OLD;
          state_nxt   = ST_DONE;
        end else if (diff_r == '0) begin
          state_nxt = ST_STEP;
        end else if (diff_r <= SW'(w_r)) begin
          if (bitmap_r[idx_win]) begin
            outcome_nxt = OUT_OLD;
          end else begin
            bitmap_nxt[idx_win] = 1'b1;
            outcome_nxt         = OUT_ACCEPT;
          end
          state_nxt = ST_DONE;
        end else begin
          moved_nxt = '0;
          state_nxt = ST_JUMP;
        end
      end
      ST_STEP: begin
        exp_nxt     = adv_exp;
        bitmap_nxt  = adv_bitmap;
        outcome_nxt = OUT_ACCEPT;
        state_nxt   = ST_DONE;
      end
      ST_JUMP: begin
        exp_nxt    = adv_exp;
        bitmap_nxt = adv_bitmap;
        moved_nxt  = moved_sum;
        if (moved_sum >= MW'(w_r) || SW'(jsum) > diff_r) begin
          state_nxt = ST_JEND;
        end
      end
      ST_JEND: begin
        priority if (SW'(moved_r) == diff_r) begin
          state_nxt = ST_STEP;
        end else if (moved_r >= MW'(w_r)) begin
          exp_nxt     = n_r + SW'(1);
          bitmap_nxt  = '0;
          outcome_nxt = OUT_OVERFLOW;
          state_nxt   = ST_DONE;
        end else begin
          bitmap_nxt[idx_jump] = 1'b1;
          outcome_nxt          = OUT_OVERFLOW;
          state_nxt            = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = outcome_r;
          out_next_nxt    = SEQ_NUM_W'(exp_r);
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      if (reg_sel_t'(paddr[2]) == REG_START_SEQUENCE) begin
        start_nxt  = pwdata;
        exp_nxt    = SW'(pwdata);
        bitmap_nxt = '0;
      end else begin
        window_nxt = pwdata[WIN_CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WIN_CFG_W'(64);
      start_r     <= '0;
      exp_r       <= '0;
      bitmap_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      start_r     <= start_nxt;
      exp_r       <= exp_nxt;
      bitmap_r    <= bitmap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r           <= n_nxt;
    diff_r        <= diff_nxt;
    lt_r          <= lt_nxt;
    w_r           <= w_nxt;
    moved_r       <= moved_nxt;
    outcome_r     <= outcome_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_next_r    <= out_next_nxt;
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (opcode_t'(in_ch.opcode) == OP_RESTART) && !cfg_wr
    |=> exp_r == '0 && bitmap_r == '0)
    else $error("restart did not clear the window state");

  a_jump_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_JUMP |-> moved_r < MW'(w_r))
    else $error("jump loop ran past the window");

  a_jump_not_past: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_JEND |-> SW'(moved_r) <= diff_r)
    else $error("jump advanced beyond the received number");

endmodule
